@@ hdl/entity_id_free_list_allocator_top_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ENTITY_ID_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define ENTITY_ID_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIDFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EIDFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/eidfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package eidfl_pkg;

  localparam int SLOT_COUNT_DEF = 1024;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 10;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_QUERY   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_DEAD      = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ hdl/eidfl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per item.
interface eidfl_req_if;
  logic                        valid;
  logic                        ready;
  logic [eidfl_pkg::KIND_W-1:0] kind;
  logic [eidfl_pkg::ID_W-1:0]   entity_id;

  modport source (output valid, kind, entity_id, input ready);
  modport sink   (input valid, kind, entity_id, output ready);
endinterface

// Result channel: one result item per request item.
interface eidfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [eidfl_pkg::ID_W-1:0]     result_id;
  logic                          is_alive;
  logic [eidfl_pkg::STATUS_W-1:0] status;

  modport source (output valid, result_id, is_alive, status, input ready);
  modport sink   (input valid, result_id, is_alive, status, output ready);
endinterface

`default_nettype wire

@@ hdl/eidfl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module eidfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/entity_id_free_list_allocator_top.sv @@
// Slot identifier allocator with a last-in, first-out free list. Each request item
// is a create, a destroy or an alive query and yields exactly one result item.
// Create reuses the most recently destroyed slot and otherwise takes the next
// never-used index, reporting "full" once every slot is in use. Destroy and query
// report a bad index for identifiers at or above the high-water count, and destroy
// of a dead slot is refused. An item is accepted in the idle state, where the slot
// memory is read (at the free-list head for a create, at the identifier otherwise),
// and finished in the execute state, where the registered read data is used, the
// entry written back and the result registered. No new item is taken until the
// execute state of the last one is done; a stalled result holds the block after at
// most one further item. The slot memory needs no clearing pass after reset: only
// entries below the high-water count are ever used, and each of those was written
// when it was handed out.
`timescale 1ns / 1ps
`default_nettype none

module entity_id_free_list_allocator_top #(
  parameter int SLOT_COUNT = eidfl_pkg::SLOT_COUNT_DEF
) (
  input wire logic       clk,
  input wire logic       rst_n,
  eidfl_req_if.sink      in_ch,
  eidfl_rsp_if.source    out_ch
);

  import eidfl_pkg::*;

  `include "entity_id_free_list_allocator_top_macros.svh"

  // Slot index width, head width (one more, for the empty mark) and count width.
  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int HW   = SW + 1;
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int CMPW = (CW > ID_W) ? CW : ID_W;
  // Each memory entry holds the alive bit above the next link.
  localparam int MW   = HW + 1;

  localparam logic [HW-1:0] HEAD_EMPTY = HW'(SLOT_COUNT);
  localparam logic [CW-1:0] CNT_FULL   = CW'(SLOT_COUNT);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r;
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   id_r;
  logic [HW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     used_r, used_nxt;

  logic                out_valid_r;
  logic [ID_W-1:0]     out_id_r;
  logic                out_alive_r;
  logic [STATUS_W-1:0] out_status_r;

  logic in_fire;
  logic exec_go;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [MW-1:0] rd_data;
  logic          wr_req;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  logic          alive_rd;
  logic [HW-1:0] link_rd;
  logic          id_bad;

  logic [ID_W-1:0] res_id;
  logic            res_alive;
  status_t         res_status;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // The result register is free when empty or being drained this cycle.
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // A create reads the link of the free-list head; other kinds read the slot itself.
  assign rd_en   = in_fire;
  assign rd_addr = (kind_t'(in_ch.kind) == KIND_CREATE) ? head_r[SW-1:0]
                                                         : SW'(in_ch.entity_id);

  eidfl_ram #(
    .WIDTH (MW),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign alive_rd = rd_data[MW-1];
  assign link_rd  = rd_data[HW-1:0];
  assign id_bad   = CMPW'(id_r) >= CMPW'(used_r);
  assign wr_en    = exec_go && wr_req;

  // Read-modify-write of the slot memory and the list pointers.
  always_comb begin
    head_nxt   = head_r;
    used_nxt   = used_r;
    wr_req     = 1'b0;
    wr_addr    = SW'(id_r);
    wr_data    = '0;
    res_id     = id_r;
    res_alive  = 1'b0;
    res_status = ST_OK;
    case (kind_t'(kind_r))
      KIND_CREATE: begin
        if (head_r != HEAD_EMPTY) begin
          // Pop the most recently freed slot.
          wr_req    = 1'b1;
          wr_addr   = head_r[SW-1:0];
          wr_data   = {1'b1, link_rd};
          head_nxt  = link_rd;
          res_id    = ID_W'(head_r[SW-1:0]);
          res_alive = 1'b1;
        end else if (used_r != CNT_FULL) begin
          // Take the next index that has never been handed out.
          wr_req    = 1'b1;
          wr_addr   = used_r[SW-1:0];
          wr_data   = {1'b1, HEAD_EMPTY};
          used_nxt  = CW'(used_r + 1'b1);
          res_id    = ID_W'(used_r[SW-1:0]);
          res_alive = 1'b1;
        end else begin
          res_id     = '0;
          res_status = ST_FULL;
        end
      end
      KIND_DESTROY: begin
        if (id_bad) begin
          res_status = ST_BAD_INDEX;
        end else if (!alive_rd) begin
          res_status = ST_DEAD;
        end else begin
          // Push the slot onto the free list.
          wr_req   = 1'b1;
          wr_data  = {1'b0, head_r};
          head_nxt = HW'(id_r);
        end
      end
      default: begin
        // Query, and the unused kind code, change no state.
        if (id_bad) begin
          res_status = ST_BAD_INDEX;
        end else begin
          res_alive = alive_rd;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= HEAD_EMPTY;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (exec_go) begin
        head_r      <= head_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      kind_r <= in_ch.kind;
      id_r   <= in_ch.entity_id;
    end
    if (exec_go) begin
      out_id_r     <= res_id;
      out_alive_r  <= res_alive;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_id = out_id_r;
  assign out_ch.is_alive  = out_alive_r;
  assign out_ch.status    = out_status_r;

  `EIDFL_ASSERT_NEXT(a_busy_after_accept, in_fire, (state_r == S_EXEC) && !in_ch.ready,
                     "allocator accepted an item while busy")
  `EIDFL_ASSERT_NOW(a_used_bounded, 1'b1, used_r <= CNT_FULL,
                    "high-water count exceeds the slot count")
  `EIDFL_ASSERT_NOW(a_head_in_range, 1'b1,
                    (head_r == HEAD_EMPTY) || (CW'(head_r) < used_r),
                    "free-list head points outside the used range")
  `EIDFL_ASSERT_NOW(a_error_not_alive, out_valid_r && (out_status_r != ST_OK),
                    !out_alive_r, "failed operation reports a live slot")

endmodule

`default_nettype wire
